// File: design/tps_pkg.sv
// Shared types and constants of the text pre-tokenizer split block.
// Used by the front, the bundle queue, the back end, the top and the checker.
package tps_pkg;

  localparam int CP_W = 21;
  localparam int MAX_RES = 3;
  localparam int RES_CNT_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // piece kinds, also used for the open run kind (none / letter / other)
  localparam logic [1:0] KIND_CONTRACTION = 2'd0;
  localparam logic [1:0] KIND_LETTER = 2'd1;
  localparam logic [1:0] KIND_DIGIT = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam logic [1:0] RUN_NONE = 2'd0;

  // character classes
  localparam logic [1:0] CLS_WS = 2'd0;
  localparam logic [1:0] CLS_LETTER = 2'd1;
  localparam logic [1:0] CLS_DIGIT = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [CP_W-1:0] APOS = 21'h27;

  localparam int LETTER_RANGES = 15;
  localparam logic [CP_W-1:0] LETTER_LO [LETTER_RANGES] = '{
    21'h00100, 21'h00370, 21'h00400, 21'h00530, 21'h00590,
    21'h00600, 21'h00900, 21'h00E00, 21'h01100, 21'h03040,
    21'h03400, 21'h04E00, 21'h0AC00, 21'h0F900, 21'h20000};
  localparam logic [CP_W-1:0] LETTER_HI [LETTER_RANGES] = '{
    21'h002AF, 21'h003FF, 21'h004FF, 21'h0058F, 21'h005FF,
    21'h006FF, 21'h0097F, 21'h00E7F, 21'h011FF, 21'h030FF,
    21'h04DBF, 21'h09FFF, 21'h0D7A3, 21'h0FAFF, 21'h2FA1F};

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      kind;
    logic            pend;
  } result_t;

  // all results caused by one input item
  typedef struct packed {
    result_t [MAX_RES-1:0]  res;
    logic [RES_CNT_W-1:0]   cnt;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } bundle_req_t;

endpackage

// File: design/tps_ifs.sv
// Stream interfaces of the pre-tokenizer split block: codepoint input and
// piece result output. Depends on nothing.
interface tps_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        final_item;

  modport source(output valid, codepoint, final_item, input ready);
  modport sink(input valid, codepoint, final_item, output ready);
endinterface

interface tps_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] out_codepoint;
  logic [1:0]  piece_kind;
  logic        piece_end;
  logic        last;

  modport source(output valid, out_codepoint, piece_kind, piece_end, last, input ready);
  modport sink(input valid, out_codepoint, piece_kind, piece_end, last, output ready);
endinterface

// File: design/text_pretokenizer_split_top.sv
// Top level of the text pre-tokenizer split block.
// Depends on tps_pkg, tps_ifs, tps_front, tps_queue and tps_back.

// One codepoint is accepted per cycle while the four-entry bundle queue has
// room. Each item yields zero to three results (contraction pieces, letter
// runs, single digits, other-character runs; whitespace yields nothing, and
// the last codepoint of an open run comes out only when the run ends or the
// final item arrives). Results leave one per cycle while the output is ready,
// through a registered output, so an item that causes n results takes n
// output transfers; the output port is what sets the sustained rate. With
// the queue empty and the output not stalled, the first result of an item is
// written into a queue entry when the item is accepted and then loaded into
// the output register, from which it is presented.
module text_pretokenizer_split_top (
  input  logic       clk,
  input  logic       rst,
  tps_in_if.sink     text_in,
  tps_out_if.source  piece_out
);

  tps_pkg::bundle_req_t push;
  tps_pkg::bundle_req_t head;
  logic                 q_full;
  logic                 pop;

  tps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .q_full  (q_full),
    .push    (push)
  );

  tps_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  tps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .piece_out (piece_out)
  );

endmodule

// File: design/tps_front.sv
// Front end: lowercases and classifies each codepoint, runs the split state
// (open run, contraction lookahead) and pushes the item's results as one bundle.
// Depends on tps_pkg and tps_in_if.
module tps_front (
  input  logic                 clk,
  input  logic                 rst,
  tps_in_if.sink               text_in,
  input  logic                 q_full,
  output tps_pkg::bundle_req_t push
);

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_APOS = 2'd1;
  localparam logic [1:0] MODE_PAIR = 2'd2;

  localparam logic [20:0] CH_D = 21'h64;
  localparam logic [20:0] CH_E = 21'h65;
  localparam logic [20:0] CH_L = 21'h6C;
  localparam logic [20:0] CH_M = 21'h6D;
  localparam logic [20:0] CH_R = 21'h72;
  localparam logic [20:0] CH_S = 21'h73;
  localparam logic [20:0] CH_T = 21'h74;
  localparam logic [20:0] CH_V = 21'h76;

  typedef struct packed {
    logic [1:0]       run;
    logic [20:0]      held0;
    logic [1:0]       mode;
    tps_pkg::bundle_t b;
  } fst_t;

  function automatic logic is_space(logic [20:0] c);
    logic r;
    r = (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85 || c == 21'hA0 ||
        c == 21'h1680 || c == 21'h2028 || c == 21'h2029 || c == 21'h202F ||
        c == 21'h205F || c == 21'h3000 || (c >= 21'h2000 && c <= 21'h200A);
    return r;
  endfunction

  function automatic logic is_letter(logic [20:0] c);
    logic r;
    r = 1'b0;
    if (c < 21'h80) begin
      r = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    end else if (c >= 21'hC0 && c <= 21'hFF) begin
      r = (c != 21'hD7) && (c != 21'hF7);
    end else begin
      r = (c == 21'hAA) || (c == 21'hB5) || (c == 21'hBA);
      for (int i = 0; i < tps_pkg::LETTER_RANGES; i++) begin
        if (c >= tps_pkg::LETTER_LO[i] && c <= tps_pkg::LETTER_HI[i]) r = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [20:0] lower(logic [20:0] c);
    logic [20:0] r;
    r = c;
    if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7)) begin
      r = c + 21'd32;
    end
    return r;
  endfunction

  function automatic tps_pkg::bundle_t emit(tps_pkg::bundle_t b, logic [20:0] cp,
                                            logic [1:0] kind, logic pend);
    tps_pkg::bundle_t r;
    r = b;
    if (r.cnt != 2'd3) begin
      r.res[r.cnt].cp = cp;
      r.res[r.cnt].kind = kind;
      r.res[r.cnt].pend = pend;
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic fst_t close_run(fst_t s);
    fst_t r;
    r = s;
    if (r.run != tps_pkg::RUN_NONE) begin
      r.b = emit(r.b, r.held0, r.run, 1'b1);
      r.run = tps_pkg::RUN_NONE;
    end
    return r;
  endfunction

  // one codepoint outside a contraction check
  function automatic fst_t feed(fst_t s, logic [20:0] c, logic [1:0] cls, logic allow_apos);
    fst_t r;
    r = s;
    if (r.run == tps_pkg::KIND_OTHER && cls == tps_pkg::CLS_OTHER) begin
      r.b = emit(r.b, r.held0, tps_pkg::KIND_OTHER, 1'b0);
      r.held0 = c;
    end else if (r.run == tps_pkg::KIND_LETTER && cls == tps_pkg::CLS_LETTER) begin
      r.b = emit(r.b, r.held0, tps_pkg::KIND_LETTER, 1'b0);
      r.held0 = c;
    end else begin
      r = close_run(r);
      if (c == tps_pkg::APOS && allow_apos) begin
        r.mode = MODE_APOS;
        r.held0 = c;
      end else if (cls == tps_pkg::CLS_LETTER || cls == tps_pkg::CLS_OTHER) begin
        r.run = (cls == tps_pkg::CLS_LETTER) ? tps_pkg::KIND_LETTER : tps_pkg::KIND_OTHER;
        r.held0 = c;
      end else if (cls == tps_pkg::CLS_DIGIT) begin
        r.b = emit(r.b, c, tps_pkg::KIND_DIGIT, 1'b1);
      end
    end
    return r;
  endfunction

  logic [1:0]  run;
  logic [20:0] held0;
  logic [20:0] held1;
  logic [1:0]  mode;

  logic [20:0] c;
  logic [1:0]  cls;
  logic        accept;
  logic        hit;
  logic [20:0] held1_next;
  fst_t        st;

  assign text_in.ready = !q_full;
  assign accept = text_in.valid && text_in.ready;

  assign c = lower(text_in.codepoint);

  always_comb begin
    if (is_space(c)) cls = tps_pkg::CLS_WS;
    else if (is_letter(c)) cls = tps_pkg::CLS_LETTER;
    else if (c >= 21'h30 && c <= 21'h39) cls = tps_pkg::CLS_DIGIT;
    else cls = tps_pkg::CLS_OTHER;
  end

  assign hit = ((held1 == CH_R || held1 == CH_V) && c == CH_E) ||
               (held1 == CH_L && c == CH_L);

  always_comb begin
    st.run = run;
    st.held0 = held0;
    st.mode = mode;
    st.b = '0;
    held1_next = held1;
    unique case (mode)
      MODE_APOS: begin
        if (c == CH_S || c == CH_T || c == CH_M || c == CH_D) begin
          st.b = emit(st.b, tps_pkg::APOS, tps_pkg::KIND_CONTRACTION, 1'b0);
          st.b = emit(st.b, c, tps_pkg::KIND_CONTRACTION, 1'b1);
          st.mode = MODE_NONE;
        end else if (c == CH_R || c == CH_V || c == CH_L) begin
          held1_next = c;
          st.mode = MODE_PAIR;
        end else begin
          st.mode = MODE_NONE;
          st = feed(st, tps_pkg::APOS, tps_pkg::CLS_OTHER, 1'b0);
          st = feed(st, c, cls, 1'b1);
        end
      end
      MODE_PAIR: begin
        st.mode = MODE_NONE;
        if (hit) begin
          st.b = emit(st.b, tps_pkg::APOS, tps_pkg::KIND_CONTRACTION, 1'b0);
          st.b = emit(st.b, held1, tps_pkg::KIND_CONTRACTION, 1'b0);
          st.b = emit(st.b, c, tps_pkg::KIND_CONTRACTION, 1'b1);
        end else begin
          st = feed(st, tps_pkg::APOS, tps_pkg::CLS_OTHER, 1'b0);
          st = feed(st, held1, tps_pkg::CLS_LETTER, 1'b1);
          st = feed(st, c, cls, 1'b1);
        end
      end
      default: begin
        st = feed(st, c, cls, 1'b1);
      end
    endcase

    // end of text: flush a pending check as a failed contraction, then the run
    if (text_in.final_item) begin
      if (st.mode == MODE_APOS) begin
        st.mode = MODE_NONE;
        st = feed(st, tps_pkg::APOS, tps_pkg::CLS_OTHER, 1'b0);
      end else if (st.mode == MODE_PAIR) begin
        st.mode = MODE_NONE;
        st = feed(st, tps_pkg::APOS, tps_pkg::CLS_OTHER, 1'b0);
        st = feed(st, held1_next, tps_pkg::CLS_LETTER, 1'b1);
      end
      st = close_run(st);
    end
  end

  assign push.valid = accept && (st.b.cnt != 2'd0);
  assign push.data = st.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= tps_pkg::RUN_NONE;
      mode <= MODE_NONE;
      held0 <= '0;
      held1 <= '0;
    end else if (accept) begin
      if (text_in.final_item) begin
        run <= tps_pkg::RUN_NONE;
        mode <= MODE_NONE;
        held0 <= '0;
        held1 <= '0;
      end else begin
        run <= st.run;
        mode <= st.mode;
        held0 <= st.held0;
        held1 <= held1_next;
      end
    end
  end

endmodule

// File: design/tps_queue.sv
// Short queue of result bundles between the front and back ends.
// Depends on tps_pkg.
module tps_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  tps_pkg::bundle_req_t push,
  input  logic                 pop,
  output tps_pkg::bundle_req_t head,
  output logic                 full
);

  tps_pkg::bundle_t entries [tps_pkg::QUEUE_DEPTH];

  logic [tps_pkg::QPTR_W-1:0] wr_ptr;
  logic [tps_pkg::QPTR_W-1:0] rd_ptr;
  logic [tps_pkg::QPTR_W:0]   count;

  logic do_push;
  logic do_pop;

  assign full = (count == (tps_pkg::QPTR_W + 1)'(tps_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.data = entries[rd_ptr];

  assign do_push = push.valid && !full;
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// File: design/tps_back.sv
// Back end: walks the head bundle one result per transfer into the output
// register and marks the last result of each item. Depends on tps_pkg, tps_out_if.
module tps_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tps_pkg::bundle_req_t head,
  output logic                 pop,
  tps_out_if.source            piece_out
);

  logic [tps_pkg::RES_CNT_W-1:0] idx;
  logic                          out_valid;
  tps_pkg::result_t              out_res;
  logic                          out_last;

  logic load;
  logic idx_last;

  assign idx_last = ((idx + 2'd1) == head.data.cnt);
  assign load = head.valid && (!out_valid || piece_out.ready);
  assign pop = load && idx_last;

  assign piece_out.valid = out_valid;
  assign piece_out.out_codepoint = out_res.cp;
  assign piece_out.piece_kind = out_res.kind;
  assign piece_out.piece_end = out_res.pend;
  assign piece_out.last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx <= idx_last ? '0 : idx + 2'd1;
    end else if (piece_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= head.data.res[idx];
      out_last <= idx_last;
    end
  end

endmodule

// File: design/tps_checker.sv
// Port-level checks of the pre-tokenizer split block, bound to its top level.
// Depends on tps_pkg and text_pretokenizer_split_top.
module tps_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_codepoint,
  input logic [1:0]  piece_kind,
  input logic        piece_end
);

  // a stalled transfer keeps its result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_codepoint) && $stable(piece_kind))
    else $error("output result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a digit is always a piece of its own
  a_digit_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && piece_kind == tps_pkg::KIND_DIGIT |-> piece_end)
    else $error("digit piece without end mark");

  // a contraction ends on a letter, never on the apostrophe
  a_contr_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && piece_kind == tps_pkg::KIND_CONTRACTION && piece_end
      |-> out_codepoint != tps_pkg::APOS)
    else $error("contraction ends on apostrophe");

endmodule

bind text_pretokenizer_split_top tps_checker u_tps_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (piece_out.valid),
  .out_ready     (piece_out.ready),
  .out_codepoint (piece_out.out_codepoint),
  .piece_kind    (piece_out.piece_kind),
  .piece_end     (piece_out.piece_end)
);

// File: verif/tb_text_pretokenizer_split_top.sv
// Testbench for text_pretokenizer_split_top: drives codepoint texts and checks every piece.
// A local model of the splitter predicts each piece.
// Depends on tps_pkg, tps_ifs and the RTL of the block.
`timescale 1ns / 1ps

module tb_text_pretokenizer_split_top;

  localparam int HALF_PERIOD = 6;
  localparam int MAX_SHOWN = 10;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;

  // contraction check state
  localparam logic [1:0] CHK_NONE = 2'd0;
  localparam logic [1:0] CHK_APOS = 2'd1;
  localparam logic [1:0] CHK_APOS_RVL = 2'd2;

  localparam logic [tps_pkg::CP_W-1:0] CH_0 = 21'h30;
  localparam logic [tps_pkg::CP_W-1:0] CH_D = 21'h64;
  localparam logic [tps_pkg::CP_W-1:0] CH_E = 21'h65;
  localparam logic [tps_pkg::CP_W-1:0] CH_L = 21'h6C;
  localparam logic [tps_pkg::CP_W-1:0] CH_M = 21'h6D;
  localparam logic [tps_pkg::CP_W-1:0] CH_R = 21'h72;
  localparam logic [tps_pkg::CP_W-1:0] CH_S = 21'h73;
  localparam logic [tps_pkg::CP_W-1:0] CH_T = 21'h74;
  localparam logic [tps_pkg::CP_W-1:0] CH_V = 21'h76;
  localparam logic [tps_pkg::CP_W-1:0] CP_TOP = 21'h1FFFFF;

  localparam logic [tps_pkg::CP_W-1:0] ALPHA_FIRST [15] = '{
    21'h00100, 21'h00370, 21'h00400, 21'h00530, 21'h00590,
    21'h00600, 21'h00900, 21'h00E00, 21'h01100, 21'h03040,
    21'h03400, 21'h04E00, 21'h0AC00, 21'h0F900, 21'h20000};
  localparam logic [tps_pkg::CP_W-1:0] ALPHA_LAST [15] = '{
    21'h002AF, 21'h003FF, 21'h004FF, 21'h0058F, 21'h005FF,
    21'h006FF, 21'h0097F, 21'h00E7F, 21'h011FF, 21'h030FF,
    21'h04DBF, 21'h09FFF, 21'h0D7A3, 21'h0FAFF, 21'h2FA1F};

  // 0x2000 stands for the whole 0x2000..0x200A block
  localparam logic [tps_pkg::CP_W-1:0] BLANK_CPS [16] = '{
    21'h09, 21'h0A, 21'h0B, 21'h0C, 21'h0D, 21'h20, 21'h85, 21'hA0,
    21'h1680, 21'h2000, 21'h200A, 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000};

  // bit 21 marks the final codepoint of a text
  localparam logic [21:0] DIRECTED_TEXT [28] = '{
    22'h000000,                          // lowest codepoint, other run
    22'h000041, 22'h000027,              // capital, then apostrophe closes the run
    22'h00004C, 22'h00006C,              // 'll with capital L
    22'h000027, 22'h000072, 22'h000045,  // 're, three pieces from one item
    22'h00000A,
    22'h000027, 22'h000076, 22'h000078,  // 'v then x: failed two-char check
    22'h000021, 22'h000027,              // apostrophe joins an open other run
    22'h000039, 22'h000030,              // digits are single pieces
    22'h0000C0, 22'h0000D7, 22'h0000DE, 22'h0000F7,
    22'h1FFFFF,                          // above U+10FFFF
    22'h003000, 22'h02FA1F,
    22'h000027, 22'h000053,              // 's with capital S
    22'h200027,                          // text ends with apostrophe held
    22'h000027, 22'h200056};             // text ends with apostrophe and v held

  typedef struct packed {
    logic [tps_pkg::CP_W-1:0] cp;
    logic [1:0]               kind;
    logic                     pend;
    logic                     last;
  } piece_t;

  logic clk = 1'b0;
  logic rst;

  tps_in_if  text_in();
  tps_out_if piece_out();

  text_pretokenizer_split_top uut (
    .clk(clk),
    .rst(rst),
    .text_in(text_in),
    .piece_out(piece_out)
  );

  always #HALF_PERIOD clk = ~clk;

  // splitter model state
  logic [tps_pkg::CP_W-1:0] tail_cp;
  logic [tps_pkg::CP_W-1:0] look_cp;
  logic [1:0]               run_kind;
  logic [1:0]               check_mode;
  piece_t                   step_pieces[$];
  piece_t                   pending_pieces[$];
  logic [tps_pkg::CP_W-1:0] text_buf[$];

  int fail_count = 0;
  int pieces_checked = 0;
  int items_sent = 0;
  int chars_counted = 0;
  int texts_sent = 0;
  int in_wait_cycles = 0;
  int gap_max = 0;
  int burst_left = 0;
  int rx_stalls = 0;
  int hold_orders = 0;
  int holds_served = 0;

  function automatic logic [tps_pkg::CP_W-1:0] fold_case(logic [tps_pkg::CP_W-1:0] c);
    if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7))
      return c + 21'd32;
    return c;
  endfunction

  function automatic bit is_alpha(logic [tps_pkg::CP_W-1:0] c);
    if (c < 21'h80)
      return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    if (c >= 21'hC0 && c <= 21'hFF)
      return c != 21'hD7 && c != 21'hF7;
    if (c == 21'hAA || c == 21'hB5 || c == 21'hBA)
      return 1'b1;
    for (int k = 0; k < 15; k++)
      if (c >= ALPHA_FIRST[k] && c <= ALPHA_LAST[k])
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_blank(logic [tps_pkg::CP_W-1:0] c);
    if (c >= 21'h09 && c <= 21'h0D)
      return 1'b1;
    if (c == 21'h20 || c == 21'h85 || c == 21'hA0 || c == 21'h1680 || c == 21'h2028 ||
        c == 21'h2029 || c == 21'h202F || c == 21'h205F || c == 21'h3000)
      return 1'b1;
    return c >= 21'h2000 && c <= 21'h200A;
  endfunction

  function automatic logic [1:0] char_class(logic [tps_pkg::CP_W-1:0] c);
    if (is_blank(c))
      return tps_pkg::CLS_WS;
    if (is_alpha(c))
      return tps_pkg::CLS_LETTER;
    if (c >= CH_0 && c <= 21'h39)
      return tps_pkg::CLS_DIGIT;
    return tps_pkg::CLS_OTHER;
  endfunction

  function automatic void reset_splitter();
    tail_cp = '0;
    look_cp = '0;
    run_kind = tps_pkg::RUN_NONE;
    check_mode = CHK_NONE;
  endfunction

  function automatic void add_cp(logic [tps_pkg::CP_W-1:0] c);
    text_buf = {text_buf, c};
  endfunction

  function automatic void add_piece(logic [tps_pkg::CP_W-1:0] c, logic [1:0] kind, logic pend);
    piece_t p;
    if (step_pieces.size() < tps_pkg::MAX_RES) begin
      p.cp = c;
      p.kind = kind;
      p.pend = pend;
      p.last = 1'b0;
      step_pieces = {step_pieces, p};
    end
  endfunction

  function automatic void end_run();
    if (run_kind != tps_pkg::RUN_NONE) begin
      add_piece(tail_cp, run_kind, 1'b1);
      run_kind = tps_pkg::RUN_NONE;
    end
  endfunction

  // one lowercased codepoint outside a contraction check
  function automatic void take_char(logic [tps_pkg::CP_W-1:0] c, bit apos_ok);
    logic [1:0] cls;
    cls = char_class(c);
    if ((run_kind == tps_pkg::KIND_OTHER && cls == tps_pkg::CLS_OTHER) ||
        (run_kind == tps_pkg::KIND_LETTER && cls == tps_pkg::CLS_LETTER)) begin
      add_piece(tail_cp, run_kind, 1'b0);
      tail_cp = c;
      return;
    end
    end_run();
    if (c == tps_pkg::APOS && apos_ok) begin
      check_mode = CHK_APOS;
      tail_cp = c;
      return;
    end
    if (cls == tps_pkg::CLS_LETTER) begin
      run_kind = tps_pkg::KIND_LETTER;
      tail_cp = c;
    end else if (cls == tps_pkg::CLS_OTHER) begin
      run_kind = tps_pkg::KIND_OTHER;
      tail_cp = c;
    end else if (cls == tps_pkg::CLS_DIGIT) begin
      add_piece(c, tps_pkg::KIND_DIGIT, 1'b1);
    end
  endfunction

  function automatic void predict_pieces(logic [tps_pkg::CP_W-1:0] cp, bit fin);
    logic [tps_pkg::CP_W-1:0] c;
    logic [tps_pkg::CP_W-1:0] prev;
    bit hit;
    c = fold_case(cp);
    prev = look_cp;
    step_pieces.delete();
    if (check_mode == CHK_APOS) begin
      if (c == CH_S || c == CH_T || c == CH_M || c == CH_D) begin
        add_piece(tps_pkg::APOS, tps_pkg::KIND_CONTRACTION, 1'b0);
        add_piece(c, tps_pkg::KIND_CONTRACTION, 1'b1);
        check_mode = CHK_NONE;
      end else if (c == CH_R || c == CH_V || c == CH_L) begin
        look_cp = c;
        check_mode = CHK_APOS_RVL;
      end else begin
        check_mode = CHK_NONE;
        take_char(tps_pkg::APOS, 1'b0);
        take_char(c, 1'b1);
      end
    end else if (check_mode == CHK_APOS_RVL) begin
      hit = ((prev == CH_R || prev == CH_V) && c == CH_E) || (prev == CH_L && c == CH_L);
      check_mode = CHK_NONE;
      if (hit) begin
        add_piece(tps_pkg::APOS, tps_pkg::KIND_CONTRACTION, 1'b0);
        add_piece(prev, tps_pkg::KIND_CONTRACTION, 1'b0);
        add_piece(c, tps_pkg::KIND_CONTRACTION, 1'b1);
      end else begin
        take_char(tps_pkg::APOS, 1'b0);
        take_char(prev, 1'b1);
        take_char(c, 1'b1);
      end
    end else begin
      take_char(c, 1'b1);
    end
    if (fin) begin
      // held lookahead comes out as a failed contraction
      if (check_mode == CHK_APOS) begin
        check_mode = CHK_NONE;
        take_char(tps_pkg::APOS, 1'b0);
      end else if (check_mode == CHK_APOS_RVL) begin
        check_mode = CHK_NONE;
        take_char(tps_pkg::APOS, 1'b0);
        take_char(look_cp, 1'b1);
      end
      end_run();
      reset_splitter();
    end
    if (step_pieces.size() > 0)
      step_pieces[step_pieces.size() - 1].last = 1'b1;
    pending_pieces = {pending_pieces, step_pieces};
  endfunction

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%s", msg);
  endtask

  task automatic check_piece();
    piece_t want;
    piece_t got;
    got.cp = piece_out.out_codepoint;
    got.kind = piece_out.piece_kind;
    got.pend = piece_out.piece_end;
    got.last = piece_out.last;
    if (pending_pieces.size() == 0) begin
      report_fail($sformatf("unexpected piece: cp=%h kind=%0d end=%b last=%b",
                            got.cp, got.kind, got.pend, got.last));
    end else begin
      want = pending_pieces.pop_front();
      pieces_checked++;
      if (got.cp !== want.cp || got.kind !== want.kind || got.pend !== want.pend ||
          got.last !== want.last)
        report_fail({
          $sformatf("piece %0d mismatch: expected cp=%h kind=%0d end=%b last=%b,",
                    pieces_checked, want.cp, want.kind, want.pend, want.last),
          $sformatf(" got cp=%h kind=%0d end=%b last=%b",
                    got.cp, got.kind, got.pend, got.last)});
    end
  endtask

  always @(posedge clk) begin
    if (!rst && text_in.valid && !text_in.ready)
      in_wait_cycles++;
    if (!rst && piece_out.valid && piece_out.ready)
      check_piece();
  end

  // output side: a random stall window that repeats while stalls are enabled, plus an ordered long hold-off
  initial begin : receiver
    int hold_left;
    int win_pos;
    int stall_at;
    int stall_len;
    hold_left = 0;
    win_pos = 0;
    stall_at = 0;
    stall_len = 0;
    piece_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_orders) begin
        holds_served = hold_orders;
        hold_left = HOLD_CYCLES;
      end
      if (win_pos == 0) begin
        stall_at = $urandom_range(0, 15);
        stall_len = $urandom_range(0, 6);
      end
      if (hold_left > 0) begin
        piece_out.ready <= 1'b0;
        hold_left--;
      end else if (rx_stalls != 0) begin
        piece_out.ready <= !(win_pos >= stall_at && win_pos < stall_at + stall_len);
      end else begin
        piece_out.ready <= 1'b1;
      end
      win_pos = (win_pos + 1) % 16;
    end
  end

  // valid stays high across back-to-back transfers; it drops only for a gap
  task automatic send_cp(input logic [tps_pkg::CP_W-1:0] cp, input bit fin);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, gap_max);
      text_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    text_in.valid <= 1'b1;
    text_in.codepoint <= cp;
    text_in.final_item <= fin;
    do @(posedge clk); while (!text_in.ready);
    predict_pieces(cp, fin);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_cp(text_buf[i], i == text_buf.size() - 1);
      if (char_class(fold_case(text_buf[i])) != tps_pkg::CLS_WS)
        chars_counted++;
    end
    texts_sent++;
  endtask

  task automatic wait_idle();
    text_in.valid <= 1'b0;
    do @(posedge clk); while (pending_pieces.size() != 0);
  endtask

  function automatic logic [tps_pkg::CP_W-1:0] any_case(logic [tps_pkg::CP_W-1:0] c);
    return ($urandom_range(0, 1) != 0) ? c - 21'd32 : c;
  endfunction

  function automatic logic [tps_pkg::CP_W-1:0] rand_letter();
    int k;
    logic [tps_pkg::CP_W-1:0] c;
    k = $urandom_range(0, 14);
    case ($urandom_range(0, 4))
      0: c = 21'h41 + tps_pkg::CP_W'($urandom_range(0, 25));
      1: c = 21'h61 + tps_pkg::CP_W'($urandom_range(0, 25));
      2: begin
        c = 21'hC0 + tps_pkg::CP_W'($urandom_range(0, 63));
        if (c == 21'hD7 || c == 21'hF7)
          c = c + 21'd1;
      end
      3: c = ($urandom_range(0, 1) != 0) ? ALPHA_FIRST[k] : ALPHA_LAST[k];
      default: c = ALPHA_FIRST[k] +
                   tps_pkg::CP_W'($urandom_range(0, ALPHA_LAST[k] - ALPHA_FIRST[k]));
    endcase
    return c;
  endfunction

  function automatic logic [tps_pkg::CP_W-1:0] rand_other();
    case ($urandom_range(0, 4))
      0: return tps_pkg::CP_W'($urandom_range(21'h21, 21'h2F));
      1: return tps_pkg::CP_W'($urandom_range(21'h3A, 21'h40));
      2: return tps_pkg::CP_W'($urandom_range(21'h5B, 21'h60));
      3: return tps_pkg::CP_W'($urandom_range(21'h7B, 21'h7F));
      default: return tps_pkg::CP_W'($urandom_range(21'h110000, CP_TOP));
    endcase
  endfunction

  function automatic logic [tps_pkg::CP_W-1:0] rand_blank();
    logic [tps_pkg::CP_W-1:0] c;
    c = BLANK_CPS[$urandom_range(0, 15)];
    if (c == 21'h2000)
      c = c + tps_pkg::CP_W'($urandom_range(0, 10));
    return c;
  endfunction

  function automatic logic [tps_pkg::CP_W-1:0] rand_digit();
    return CH_0 + tps_pkg::CP_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [tps_pkg::CP_W-1:0] rand_any();
    case ($urandom_range(0, 3))
      0: return rand_letter();
      1: return rand_digit();
      2: return rand_other();
      default: return rand_blank();
    endcase
  endfunction

  function automatic void add_contraction();
    add_cp(tps_pkg::APOS);
    case ($urandom_range(0, 6))
      0: add_cp(any_case(CH_S));
      1: add_cp(any_case(CH_T));
      2: add_cp(any_case(CH_M));
      3: add_cp(any_case(CH_D));
      4: begin
        add_cp(any_case(CH_R));
        add_cp(any_case(CH_E));
      end
      5: begin
        add_cp(any_case(CH_V));
        add_cp(any_case(CH_E));
      end
      default: begin
        add_cp(any_case(CH_L));
        add_cp(any_case(CH_L));
      end
    endcase
  endfunction

  // mostly well-formed words, contractions, digits and punctuation; some noise
  function automatic void add_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 6)) add_cp(rand_letter());
    end else if (pick < 40) begin
      add_contraction();
    end else if (pick < 50) begin
      repeat ($urandom_range(1, 4)) add_cp(rand_digit());
    end else if (pick < 62) begin
      repeat ($urandom_range(1, 4)) add_cp(rand_other());
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 3)) add_cp(rand_blank());
    end else if (pick < 88) begin
      // apostrophe and r, v or l, then anything (or the text ends)
      add_cp(tps_pkg::APOS);
      case ($urandom_range(0, 2))
        0: add_cp(any_case(CH_R));
        1: add_cp(any_case(CH_V));
        default: add_cp(any_case(CH_L));
      endcase
      if ($urandom_range(0, 1) != 0)
        add_cp(rand_any());
    end else if (pick < 92) begin
      add_cp(tps_pkg::APOS);
    end else begin
      repeat ($urandom_range(1, 2)) add_cp(tps_pkg::CP_W'($urandom_range(0, CP_TOP)));
    end
  endfunction

  task automatic test_directed_cases();
    gap_max = 3;
    rx_stalls = 1;
    burst_left = 0;
    for (int i = 0; i < $size(DIRECTED_TEXT); i++)
      send_cp(DIRECTED_TEXT[i][tps_pkg::CP_W-1:0], DIRECTED_TEXT[i][tps_pkg::CP_W]);
    wait_idle();
  endtask

  task automatic test_random_text(input int n_chars, input int gaps, input int stalls);
    int target;
    gap_max = gaps;
    rx_stalls = stalls;
    burst_left = 0;
    target = chars_counted + n_chars;
    while (chars_counted < target) begin
      text_buf.delete();
      repeat ($urandom_range(1, 10)) add_token();
      send_text();
    end
  endtask

  // output held off while input keeps offering: queue fills, input must stall
  task automatic test_output_hold();
    gap_max = 0;
    rx_stalls = 0;
    hold_orders++;
    text_buf.delete();
    for (int i = 0; i < 40; i++)
      add_cp((i % 2 != 0) ? rand_other() : rand_letter());
    send_text();
    wait_idle();
  endtask

  initial begin
    int guard;
    rst <= 1'b1;
    text_in.valid <= 1'b0;
    text_in.codepoint <= '0;
    text_in.final_item <= 1'b0;
    reset_splitter();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_text(70, 0, 0);
    test_random_text(70, 6, 0);
    test_output_hold();
    test_random_text(70, 0, 1);
    test_random_text(70, 6, 1);

    text_in.valid <= 1'b0;
    guard = 0;
    while (pending_pieces.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pieces.size() != 0) begin
      $display("%0d expected pieces never arrived", pending_pieces.size());
      fail_count += pending_pieces.size();
    end

    $display("covered %0d codepoints in %0d texts, %0d pieces checked, %0d failures",
             items_sent, texts_sent, pieces_checked, fail_count);
    $display("input waited %0d cycles on backpressure, incl. one %0d-cycle output hold-off",
             in_wait_cycles, HOLD_CYCLES);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("run timed out");
    $display("status: fail");
    $finish;
  end

endmodule
